### src/sbmf_pkg.sv
// Shared constants and helpers for the side-channel bass mono filter.
// No dependencies; every other file refers to this package by scoped names.
package sbmf_pkg;

   // Default build parameters
   localparam int EXTRA_POLES_DEF = 6;
   localparam int SAMPLE_BITS_DEF = 24;

   // Fixed field widths
   localparam int STATE_W    = 48;
   localparam int COEF_W     = 24;
   localparam int SLOPE_W    = 19;
   localparam int WEIGHT_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Golden ratio conjugate in Q0.24, and unity weight in Q1.16
   localparam logic [COEF_W-1:0]   GOLD_Q24   = 24'd10368890;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

   // Register reset values
   localparam logic [COEF_W-1:0]  CUTOFF_RESET = 24'd0;
   localparam logic [COEF_W-1:0]  FLOOR_RESET  = 24'd17;
   localparam logic [SLOPE_W-1:0] SLOPE_RESET  = 19'd0;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FLOOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SLOPE  = 2'd2;

   // Width of the operand taken by the state saturator
   localparam int SAT_W = 80;
   localparam logic signed [SAT_W-1:0] SAT_HI =
      {{(SAT_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
   localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

   // Clamp a wide signed value into the 48-bit filter state range
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [SAT_W-1:0] x);
      logic signed [STATE_W-1:0] r;
      if (x > SAT_HI) begin
         r = SAT_HI[STATE_W-1:0];
      end else if (x < SAT_LO) begin
         r = SAT_LO[STATE_W-1:0];
      end else begin
         r = x[STATE_W-1:0];
      end
      return r;
   endfunction

   // Weight of extra stage k: clamp(slope - k, 0, 1) in Q1.16
   function automatic logic [WEIGHT_W-1:0] weight_of(
      input logic [SLOPE_W-1:0] slope, input int unsigned k);
      logic [20:0] base;
      logic [20:0] s21;
      logic [WEIGHT_W-1:0] w;
      base = 21'(k) << 16;
      s21  = 21'(slope);
      if (s21 >= base + 21'(WEIGHT_ONE)) begin
         w = WEIGHT_ONE;
      end else if (s21 > base) begin
         w = WEIGHT_W'(s21 - base);
      end else begin
         w = '0;
      end
      return w;
   endfunction

endpackage

### src/sbmf_if.sv
// Handshake channels of the side-channel bass mono filter: frame in,
// frame out and register write. Depends on sbmf_pkg for field widths.
interface sbmf_req_if #(parameter int SAMPLE_BITS = sbmf_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;
   modport source (output valid, output left_in, output right_in, input ready);
   modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sbmf_rsp_if #(parameter int SAMPLE_BITS = sbmf_pkg::SAMPLE_BITS_DEF);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   modport source (output valid, output left_out, output right_out, input ready);
   modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sbmf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [sbmf_pkg::CSR_IDX_W-1:0]      index;
   logic [sbmf_pkg::CSR_DATA_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/sbmf_cell.sv
// One one-pole lowpass stage of the side-signal cascade: holds its state,
// coefficient and multipliers, and hands residue and correction downstream.
// Depends on sbmf_pkg.
module sbmf_cell #(
   parameter int TW = 48,   // residue width
   parameter int CW = 51    // correction accumulator width
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          derive,
   input  logic [sbmf_pkg::COEF_W-1:0]   floor_coef,
   input  logic [sbmf_pkg::COEF_W-1:0]   coef_up,
   output logic [sbmf_pkg::COEF_W-1:0]   coef_dn,
   input  logic [sbmf_pkg::WEIGHT_W-1:0] weight,
   input  logic                          sel,
   input  logic                          up_t_valid,
   input  logic signed [TW-1:0]          up_t,
   input  logic                          up_corr_valid,
   input  logic signed [CW-1:0]          up_corr,
   output logic                          dn_t_valid,
   output logic signed [TW-1:0]          dn_t,
   output logic                          dn_corr_valid,
   output logic signed [CW-1:0]          dn_corr
);

   localparam int SW    = sbmf_pkg::STATE_W;
   localparam int DW    = TW + 1;
   localparam int DH_W  = DW - 25;
   localparam int MA_W  = (DH_W > 25) ? DH_W : 25;
   localparam int PH_W  = MA_W + 25;
   localparam int SUM_W = ((PH_W + 25 > SW + 24) ? PH_W + 25 : SW + 24) + 2;
   localparam int CD_W  = PH_W + 2;
   localparam int WS_W  = ((CW + 16 > 66) ? CW + 16 : 66) + 2;

   localparam logic [SUM_W-1:0] RND24 = SUM_W'(1) << 23;
   localparam logic [CD_W-1:0]  RND24C = CD_W'(1) << 23;
   localparam logic [WS_W-1:0]  RND16 = WS_W'(1) << 15;

   logic [3:0]               phase_ff, phase_in;
   logic signed [SW-1:0]     s0_ff, s1_ff;
   logic signed [TW-1:0]     t_ff;
   logic signed [DW-1:0]     d_ff;
   logic [48:0]              ml_ff;
   logic signed [PH_W-1:0]   mh_ff;
   logic [sbmf_pkg::COEF_W-1:0] coef_ff;
   logic [40:0]              wl_ff;
   logic signed [41:0]       wh_ff;
   logic signed [CW-1:0]     corr_ff;
   logic                     dn_t_valid_ff, dn_corr_valid_ff;
   logic signed [TW-1:0]     dn_t_ff;
   logic signed [CW-1:0]     dn_corr_ff;

   logic signed [SW-1:0]     s_cur;
   logic signed [DW-1:0]     d_diff;
   logic signed [24:0]       cdiff;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [24:0]       mul_b;
   logic signed [PH_W-1:0]   mh_prod;
   logic [48:0]              ml_prod;
   logic signed [SUM_W-1:0]  s_sum;
   logic signed [SW-1:0]     s_new;
   logic signed [TW-1:0]     t_new;
   logic [40:0]              wl_prod;
   logic signed [41:0]       wh_prod;
   logic signed [WS_W-1:0]   c_sum;
   logic signed [CW-1:0]     corr_new;
   logic signed [CD_W-1:0]   cd_sum;

   // Phase shift line: difference, multiply, state update, weight, correction
   assign phase_in = {phase_ff[2:0], up_t_valid};
   assign s_cur    = sel ? s1_ff : s0_ff;
   assign d_diff   = DW'(up_t) - DW'(s_cur);

   // High partial product shares its multiplier with coefficient derivation
   assign cdiff   = $signed({1'b0, coef_ff}) - $signed({1'b0, floor_coef});
   assign mul_a   = derive ? MA_W'(cdiff) : MA_W'($signed(d_ff[DW-1:25]));
   assign mul_b   = derive ? $signed({1'b0, sbmf_pkg::GOLD_Q24}) : $signed({1'b0, coef_ff});
   assign mh_prod = mul_a * mul_b;
   assign ml_prod = d_ff[24:0] * coef_ff;

   // Next stage coefficient: floor + R24((c - floor) * G)
   assign cd_sum  = ((CD_W'(floor_coef)) << 24) + CD_W'(mh_ff) + $signed(RND24C);
   assign coef_dn = cd_sum[47:24];

   // State update: s + R24(d * a), saturated
   assign s_sum = $signed((SUM_W'(s_cur) <<< 24) + (SUM_W'(mh_ff) <<< 25)
                  + SUM_W'(ml_ff) + RND24);
   assign s_new = sbmf_pkg::sat_state(sbmf_pkg::SAT_W'(s_sum >>> 24));

   // New residue, and weight partial products of the updated state
   assign t_new   = TW'(sbmf_pkg::sat_state(sbmf_pkg::SAT_W'(t_ff) - sbmf_pkg::SAT_W'(s_cur)));
   assign wl_prod = s_cur[23:0] * weight;
   assign wh_prod = $signed(s_cur[47:24]) * $signed({1'b0, weight});

   // Correction: corr + floor((s * w + 2^15) / 2^16)
   assign c_sum    = $signed((WS_W'(corr_ff) <<< 16) + (WS_W'(wh_ff) <<< 24)
                     + WS_W'(wl_ff) + RND16);
   assign corr_new = CW'(c_sum >>> 16);

   // Control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= '0;
         s0_ff            <= '0;
         s1_ff            <= '0;
         dn_t_valid_ff    <= 1'b0;
         dn_corr_valid_ff <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         dn_t_valid_ff    <= phase_ff[2];
         dn_corr_valid_ff <= phase_ff[3];
         if (phase_ff[1]) begin
            if (sel) begin
               s1_ff <= s_new;
            end else begin
               s0_ff <= s_new;
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (up_t_valid) begin
         t_ff <= up_t;
         d_ff <= d_diff;
      end
      if (up_corr_valid) begin
         corr_ff <= up_corr;
      end
      if (derive) begin
         coef_ff <= coef_up;
      end
      if (derive || phase_ff[0]) begin
         mh_ff <= mh_prod;
      end
      if (phase_ff[0]) begin
         ml_ff <= ml_prod;
      end
      if (phase_ff[2]) begin
         dn_t_ff <= t_new;
         wl_ff   <= wl_prod;
         wh_ff   <= wh_prod;
      end
      if (phase_ff[3]) begin
         dn_corr_ff <= corr_new;
      end
   end

   assign dn_t_valid    = dn_t_valid_ff;
   assign dn_t          = dn_t_ff;
   assign dn_corr_valid = dn_corr_valid_ff;
   assign dn_corr       = dn_corr_ff;

endmodule

### src/side_channel_bass_mono_filter_core.sv
// Top level of the side-channel bass mono filter: mid/side split, cell chain,
// output rebuild and registers. Depends on sbmf_pkg, sbmf_if.sv, sbmf_cell.
//
// One stereo frame per beat in, one filtered frame per beat out. A frame
// is accepted only once the previous one has left the cell chain: the
// side residue walks a chain of EXTRA_POLES+1 stage cells, each of which
// does difference, coefficient multiply, state update and weight multiply
// before it hands on. Results wait in a two-entry output queue, so a new
// frame is taken while the previous one is still unread. After reset, and
// after every write of the cutoff or floor register, the stage coefficients
// are derived again along the chain; req_bus.ready is low during that time.
// Register writes are always taken.
module side_channel_bass_mono_filter_core #(
   parameter int EXTRA_POLES = sbmf_pkg::EXTRA_POLES_DEF,
   parameter int SAMPLE_BITS = sbmf_pkg::SAMPLE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   sbmf_req_if.sink   req_bus,
   sbmf_rsp_if.source rsp_bus,
   sbmf_csr_if.sink   csr_bus
);

   localparam int SB         = SAMPLE_BITS;
   localparam int NC         = EXTRA_POLES + 1;
   localparam int TW         = (SB + 17 > sbmf_pkg::STATE_W) ? SB + 17 : sbmf_pkg::STATE_W;
   localparam int CW         = sbmf_pkg::STATE_W + $clog2(NC + 1);
   localparam int OW         = ((SB + 18 > CW) ? SB + 18 : CW) + 2;
   localparam int DERIVE_LEN = 2 * NC;
   localparam int DCNT_W     = $clog2(DERIVE_LEN + 1);

   localparam logic signed [OW-1:0] SMP_MAX = {{(OW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [OW-1:0] SMP_MIN = ~SMP_MAX;

   // Scale down by 2^17 and clamp a rebuilt channel to the sample range
   function automatic logic signed [SB-1:0] to_sample(input logic signed [OW-1:0] x);
      logic signed [OW-1:0] q;
      logic signed [SB-1:0] r;
      q = x >>> 17;
      if (q > SMP_MAX) begin
         r = SMP_MAX[SB-1:0];
      end else if (q < SMP_MIN) begin
         r = SMP_MIN[SB-1:0];
      end else begin
         r = q[SB-1:0];
      end
      return r;
   endfunction

   // Registers
   logic signed [SB-1:0]               l_ff, r_ff;
   logic                               start_ff;
   logic                               busy_ff, busy_in;
   logic                               alt_ff, alt_in;
   logic [DCNT_W-1:0]                  dcnt_ff, dcnt_in;
   logic [sbmf_pkg::COEF_W-1:0]        cutoff_ff, floor_ff;
   logic [sbmf_pkg::SLOPE_W-1:0]       slope_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               spare_valid_ff, spare_valid_in;
   logic signed [SB-1:0]               rsp_left_ff, rsp_right_ff;
   logic signed [SB-1:0]               spare_left_ff, spare_right_ff;

   logic                               req_take, csr_take, rsp_take, derive, done;
   logic                               load_rsp_done, load_rsp_spare, load_spare;
   logic signed [SB:0]                 side_diff;
   logic signed [OW-1:0]               left_wide, right_wide;
   logic signed [SB-1:0]               left_res, right_res;

   // Cell chain links
   logic                               t_valid_link [NC];
   logic signed [TW-1:0]               t_link       [NC];
   logic                               corr_valid_link [NC+1];
   logic signed [CW-1:0]               corr_link       [NC+1];
   logic [sbmf_pkg::COEF_W-1:0]        coef_link    [NC];
   logic [sbmf_pkg::WEIGHT_W-1:0]      weight_arr   [NC];

   // Handshakes
   assign derive        = (dcnt_ff != '0);
   assign req_bus.ready = !busy_ff && !derive && !spare_valid_ff;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_take      = csr_bus.valid;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;
   assign done          = corr_valid_link[NC];

   // Chain head: side scaled by 2^16, correction starts at zero
   assign side_diff       = (SB+1)'(l_ff) - (SB+1)'(r_ff);
   assign t_valid_link[0] = start_ff;
   assign t_link[0]       = TW'(side_diff) <<< 16;
   assign corr_valid_link[0] = start_ff;
   assign corr_link[0]    = '0;
   assign coef_link[0]    = cutoff_ff;
   assign coef_link[1]    = cutoff_ff;

   // Row of stage cells; the first one is the alternating pair
   for (genvar i = 0; i < NC; i++) begin : g_cell
      if (i == 0) begin : g_w0
         assign weight_arr[i] = sbmf_pkg::WEIGHT_ONE;
      end else begin : g_wk
         assign weight_arr[i] = sbmf_pkg::weight_of(slope_ff, i - 1);
      end

      if (i == NC - 1) begin : g_last
         sbmf_cell #(.TW(TW), .CW(CW)) u_cell (
            .clock(clock), .reset(reset), .derive(derive),
            .floor_coef(floor_ff), .coef_up(coef_link[i]), .coef_dn(),
            .weight(weight_arr[i]), .sel((i == 0) ? !alt_ff : 1'b0),
            .up_t_valid(t_valid_link[i]), .up_t(t_link[i]),
            .up_corr_valid(corr_valid_link[i]), .up_corr(corr_link[i]),
            .dn_t_valid(), .dn_t(),
            .dn_corr_valid(corr_valid_link[i+1]), .dn_corr(corr_link[i+1])
         );
      end else if (i == 0) begin : g_first
         sbmf_cell #(.TW(TW), .CW(CW)) u_cell (
            .clock(clock), .reset(reset), .derive(derive),
            .floor_coef(floor_ff), .coef_up(coef_link[i]), .coef_dn(),
            .weight(weight_arr[i]), .sel(!alt_ff),
            .up_t_valid(t_valid_link[i]), .up_t(t_link[i]),
            .up_corr_valid(corr_valid_link[i]), .up_corr(corr_link[i]),
            .dn_t_valid(t_valid_link[i+1]), .dn_t(t_link[i+1]),
            .dn_corr_valid(corr_valid_link[i+1]), .dn_corr(corr_link[i+1])
         );
      end else begin : g_mid
         sbmf_cell #(.TW(TW), .CW(CW)) u_cell (
            .clock(clock), .reset(reset), .derive(derive),
            .floor_coef(floor_ff), .coef_up(coef_link[i]), .coef_dn(coef_link[i+1]),
            .weight(weight_arr[i]), .sel(1'b0),
            .up_t_valid(t_valid_link[i]), .up_t(t_link[i]),
            .up_corr_valid(corr_valid_link[i]), .up_corr(corr_link[i]),
            .dn_t_valid(t_valid_link[i+1]), .dn_t(t_link[i+1]),
            .dn_corr_valid(corr_valid_link[i+1]), .dn_corr(corr_link[i+1])
         );
      end
   end

   // Rebuild: left = (2l+1)*2^16 - corr, right = (2r+1)*2^16 + corr, then /2^17
   assign left_wide  = (OW'($signed({l_ff, 1'b1})) <<< 16) - OW'(corr_link[NC]);
   assign right_wide = (OW'($signed({r_ff, 1'b1})) <<< 16) + OW'(corr_link[NC]);
   assign left_res   = to_sample(left_wide);
   assign right_res  = to_sample(right_wide);

   // Control next state
   always_comb begin
      busy_in        = busy_ff;
      alt_in         = alt_ff;
      dcnt_in        = dcnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      spare_valid_in = spare_valid_ff;
      load_rsp_done  = 1'b0;
      load_rsp_spare = 1'b0;
      load_spare     = 1'b0;

      if (req_take) begin
         busy_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
         alt_in  = !alt_ff;
      end

      // Coefficient derivation after a cutoff or floor write
      if (csr_take && (csr_bus.index == sbmf_pkg::REG_CUTOFF ||
                       csr_bus.index == sbmf_pkg::REG_FLOOR)) begin
         dcnt_in = DCNT_W'(DERIVE_LEN);
      end else if (derive) begin
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end

      // Two-entry output queue
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (!rsp_valid_in) begin
         if (spare_valid_ff) begin
            load_rsp_spare = 1'b1;
            rsp_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end else if (done) begin
            load_rsp_done = 1'b1;
            rsp_valid_in  = 1'b1;
         end
      end
      if (done && !load_rsp_done) begin
         load_spare     = 1'b1;
         spare_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff       <= 1'b0;
         busy_ff        <= 1'b0;
         alt_ff         <= 1'b1;
         dcnt_ff        <= DCNT_W'(DERIVE_LEN);
         rsp_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
         cutoff_ff      <= sbmf_pkg::CUTOFF_RESET;
         floor_ff       <= sbmf_pkg::FLOOR_RESET;
         slope_ff       <= sbmf_pkg::SLOPE_RESET;
      end else begin
         start_ff       <= req_take;
         busy_ff        <= busy_in;
         alt_ff         <= alt_in;
         dcnt_ff        <= dcnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         spare_valid_ff <= spare_valid_in;
         if (csr_take) begin
            unique case (csr_bus.index)
               sbmf_pkg::REG_CUTOFF: cutoff_ff <= csr_bus.data;
               sbmf_pkg::REG_FLOOR:  floor_ff  <= csr_bus.data;
               sbmf_pkg::REG_SLOPE:  slope_ff  <= csr_bus.data[sbmf_pkg::SLOPE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         l_ff <= req_bus.left_in;
         r_ff <= req_bus.right_in;
      end
      if (load_rsp_spare) begin
         rsp_left_ff  <= spare_left_ff;
         rsp_right_ff <= spare_right_ff;
      end else if (load_rsp_done) begin
         rsp_left_ff  <= left_res;
         rsp_right_ff <= right_res;
      end
      if (load_spare) begin
         spare_left_ff  <= left_res;
         spare_right_ff <= right_res;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = rsp_left_ff;
   assign rsp_bus.right_out = rsp_right_ff;

endmodule
